>>> hw/rtl/lcs_pkg.sv
// ============================================================================
// lcs_pkg: shared types and constants of the LCS length unit
// Transaction payload structs, command codes and the sweep command bundle.
// ============================================================================
`default_nettype none

package lcs_pkg;

   // Default capacity of the B token store.
   localparam int MaxLenDefault = 1024;
   // Width of one line token.
   localparam int TokenBits = 32;
   // Width of the reported length field.
   localparam int LenBits = 11;

   // Request opcodes.
   localparam logic OpLoadB = 1'b0;
   localparam logic OpProcA = 1'b1;

   typedef struct packed {
      logic                 opcode;
      logic [TokenBits-1:0] token;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [LenBits-1:0] lcs_length;
      logic               too_long;
   } rsp_type;

   // Command from the sequencer to the row engine.
   typedef struct packed {
      logic                 launch;
      logic                 first_row;
      logic [TokenBits-1:0] token;
   } lcs_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/lcs_cell.sv
// ============================================================================
// lcs_cell: one dynamic programming cell update
// Takes the diagonal value plus one on a token match, else the larger of left
// and up.
// ============================================================================
`default_nettype none

module lcs_cell #(
   parameter int DpW = 11
) (
   input  wire logic [lcs_pkg::TokenBits-1:0] a_token,
   input  wire logic [lcs_pkg::TokenBits-1:0] b_token,
   input  wire logic [DpW-1:0]                diag,
   input  wire logic [DpW-1:0]                left,
   input  wire logic [DpW-1:0]                up,
   output logic      [DpW-1:0]                value
);
   import lcs_pkg::*;

   always_comb begin
      if (a_token == b_token) begin
         value = diag + DpW'(1);
      end else if (left >= up) begin
         value = left;
      end else begin
         value = up;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lcs_row_engine.sv
// ============================================================================
// lcs_row_engine: DP row sweep over the stored B tokens
// Holds the B token store and the DP row memory and walks one row entry per
// cycle through a shared cell unit.
// ============================================================================
`default_nettype none

module lcs_row_engine #(
   parameter  int MAX_LEN = lcs_pkg::MaxLenDefault,
   localparam int CntW    = $clog2(MAX_LEN + 1),
   localparam int IdxW    = $clog2(MAX_LEN)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lcs_pkg::lcs_cmd_type          cmd,
   input  wire logic [CntW-1:0]               b_len,
   input  wire logic                          b_wr_en,
   input  wire logic [IdxW-1:0]               b_wr_addr,
   input  wire logic [lcs_pkg::TokenBits-1:0] b_wr_data,
   output logic                               done,
   output logic      [CntW-1:0]               last_value
);
   import lcs_pkg::*;

   // Entry j of the row memory holds DP entry j+1; DP entry 0 is always zero.
   logic [TokenBits-1:0] b_mem_ff  [MAX_LEN];
   logic [CntW-1:0]      dp_mem_ff [MAX_LEN];

   logic                 issuing_ff, issuing_in;
   logic [IdxW-1:0]      issue_idx_ff, issue_idx_in;
   logic [CntW-1:0]      len_ff;
   logic [TokenBits-1:0] tok_ff;
   logic                 first_ff;
   logic                 cal_valid_ff;
   logic                 cal_last_ff;
   logic [IdxW-1:0]      cal_idx_ff;
   logic [TokenBits-1:0] b_rd_ff;
   logic [CntW-1:0]      dp_rd_ff;
   logic [CntW-1:0]      left_ff;
   logic [CntW-1:0]      diag_ff;

   logic [CntW-1:0]      next_count;
   logic                 issue_last;
   logic [CntW-1:0]      up_value;
   logic [CntW-1:0]      cell_value;

   assign next_count = {{(CntW - IdxW){1'b0}}, issue_idx_ff} + CntW'(1);
   assign issue_last = (next_count == len_ff);

   always_comb begin
      issuing_in   = issuing_ff;
      issue_idx_in = issue_idx_ff;
      if (cmd.launch) begin
         issuing_in   = 1'b1;
         issue_idx_in = '0;
      end else if (issuing_ff) begin
         issuing_in   = ~issue_last;
         issue_idx_in = issue_idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff   <= 1'b0;
         cal_valid_ff <= 1'b0;
      end else begin
         issuing_ff   <= issuing_in;
         cal_valid_ff <= issuing_ff;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      cal_idx_ff   <= issue_idx_ff;
      cal_last_ff  <= issue_last;
      if (cmd.launch) begin
         len_ff   <= b_len;
         tok_ff   <= cmd.token;
         first_ff <= cmd.first_row;
         left_ff  <= '0;
         diag_ff  <= '0;
      end else if (cal_valid_ff) begin
         left_ff <= cell_value;
         diag_ff <= up_value;
      end
   end

   // B token store: written by the loader, read by the sweep.
   always_ff @(posedge clock) begin
      if (b_wr_en) begin
         b_mem_ff[b_wr_addr] <= b_wr_data;
      end
      b_rd_ff <= b_mem_ff[issue_idx_ff];
   end

   // DP row: read one entry ahead of the write-back of the cell result.
   always_ff @(posedge clock) begin
      if (cal_valid_ff) begin
         dp_mem_ff[cal_idx_ff] <= cell_value;
      end
      dp_rd_ff <= dp_mem_ff[issue_idx_ff];
   end

   // The first row of an A sequence sees a cleared row above it.
   assign up_value = first_ff ? '0 : dp_rd_ff;

   lcs_cell #(
      .DpW (CntW)
   ) u_cell (
      .a_token (tok_ff),
      .b_token (b_rd_ff),
      .diag    (diag_ff),
      .left    (left_ff),
      .up      (up_value),
      .value   (cell_value)
   );

   assign done       = cal_valid_ff & cal_last_ff;
   assign last_value = cell_value;

endmodule

`default_nettype wire

>>> hw/rtl/lcs_length_dp_unit.sv
// ============================================================================
// lcs_length_dp_unit: longest common subsequence length of two token streams
// A B token is taken without raising busy. An A token against n loaded B
// tokens, n above zero, keeps busy high while the row is swept, and no new
// token is taken until busy falls; its result, if it is the last A token,
// shows in the first cycle with busy low again. With no B token loaded, an A
// token leaves busy low and a last one reports length zero on the next cycle.
// The rate is set by the DP row memory port, walked one entry per cycle.
// Reset is synchronous and clears all control state; the token store and the
// row memory are not swept or cleared by reset.
// ============================================================================
`default_nettype none

module lcs_length_dp_unit #(
   parameter int MAX_LEN = lcs_pkg::MaxLenDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire lcs_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output lcs_pkg::rsp_type      rsp_data
);
   import lcs_pkg::*;

   localparam int CntW = $clog2(MAX_LEN + 1);
   localparam int IdxW = $clog2(MAX_LEN);

   // Sequencer states.
   localparam logic StIdle  = 1'b0;
   localparam logic StSweep = 1'b1;

   logic            state_ff, state_in;
   logic [CntW-1:0] b_count_ff, b_count_in;
   logic            b_overflow_ff, b_overflow_in;
   logic            b_closed_ff, b_closed_in;
   logic            a_active_ff, a_active_in;
   logic            a_last_ff, a_last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   logic [CntW-1:0] load_base;
   logic            b_wr_en;
   logic [IdxW-1:0] b_wr_addr;
   lcs_cmd_type     cmd;
   logic            eng_done;
   logic [CntW-1:0] eng_value;

   assign accept = start & ~busy;

   // A B token that follows a closed B sequence starts a new one.
   assign load_base = b_closed_ff ? '0 : b_count_ff;
   assign b_wr_addr = load_base[IdxW-1:0];

   always_comb begin
      state_in      = state_ff;
      b_count_in    = b_count_ff;
      b_overflow_in = b_overflow_ff;
      b_closed_in   = b_closed_ff;
      a_active_in   = a_active_ff;
      a_last_in     = a_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      b_wr_en       = 1'b0;
      cmd.launch    = 1'b0;
      cmd.first_row = ~a_active_ff;
      cmd.token     = req_data.token;

      unique case (state_ff)
         StIdle: begin
            if (accept && req_data.opcode == OpLoadB) begin
               // Loading B ends any open A sequence without a result.
               a_active_in = 1'b0;
               b_closed_in = req_data.last;
               if (b_closed_ff) begin
                  b_overflow_in = 1'b0;
               end
               if (load_base < CntW'(MAX_LEN)) begin
                  b_wr_en    = 1'b1;
                  b_count_in = load_base + CntW'(1);
               end else begin
                  b_count_in    = load_base;
                  b_overflow_in = 1'b1;
               end
            end else if (accept) begin
               a_active_in = ~req_data.last;
               if (b_count_ff == '0) begin
                  // Nothing to sweep: an empty B gives length zero.
                  rsp_valid_in       = req_data.last;
                  rsp_in.lcs_length  = '0;
                  rsp_in.too_long    = b_overflow_ff;
               end else begin
                  cmd.launch = 1'b1;
                  a_last_in  = req_data.last;
                  state_in   = StSweep;
               end
            end
         end
         StSweep: begin
            if (eng_done) begin
               state_in = StIdle;
               if (a_last_ff) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.too_long   = b_overflow_ff;
                  rsp_in.lcs_length = b_overflow_ff ? '0 : LenBits'(eng_value);
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         b_count_ff    <= '0;
         b_overflow_ff <= 1'b0;
         b_closed_ff   <= 1'b0;
         a_active_ff   <= 1'b0;
         a_last_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         b_count_ff    <= b_count_in;
         b_overflow_ff <= b_overflow_in;
         b_closed_ff   <= b_closed_in;
         a_active_ff   <= a_active_in;
         a_last_ff     <= a_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   lcs_row_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .b_len      (b_count_ff),
      .b_wr_en    (b_wr_en),
      .b_wr_addr  (b_wr_addr),
      .b_wr_data  (req_data.token),
      .done       (eng_done),
      .last_value (eng_value)
   );

   assign busy      = (state_ff == StSweep);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lcs_chk.sv
// ============================================================================
// lcs_chk: port-level checks for the LCS length unit
// Watches the request and result ports and is bound to the top level.
// ============================================================================
`default_nettype none

module lcs_chk #(
   parameter int MAX_LEN = lcs_pkg::MaxLenDefault
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire lcs_pkg::req_type req_data,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire lcs_pkg::rsp_type rsp_data
);
   import lcs_pkg::*;

   logic accept;

   assign accept = start & ~busy;

   // An overflowed B sequence always reports length zero.
   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_long |-> rsp_data.lcs_length == '0)
      else $error("too_long result with nonzero length");

   // A result comes only after a sweep or an A transaction marked last.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) ||
         $past(accept && req_data.opcode == OpProcA && req_data.last))
      else $error("result without a finishing A transaction");

   // Loading B never stalls and never yields a result.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OpLoadB |=> !busy && !rsp_valid)
      else $error("B transaction caused busy or a result");

   // An A transaction that is not last gives no result right away.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OpProcA && !req_data.last |=> !rsp_valid)
      else $error("result after a non-final A transaction");

   // The reported length never exceeds the capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.lcs_length) <= MAX_LEN)
      else $error("length above capacity");

endmodule

bind lcs_length_dp_unit lcs_chk #(
   .MAX_LEN (MAX_LEN)
) u_lcs_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_data  (req_data),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
